FILE: rtl/core/tecc_pkg.sv
// ----------------------------------------------------------------------------
// tecc_pkg
// shared types and constants for the edge-biconnected component engine
// ----------------------------------------------------------------------------
package tecc_pkg;

    localparam int MaxNodes = 1024;
    localparam int MaxEdges = 4096;
    localparam int Slots    = 2 * MaxEdges;
    localparam int VW       = 10;   // vertex id
    localparam int NW       = 11;   // vertex count
    localparam int SW       = 13;   // slot index
    localparam int PW       = 14;   // slot pointer with nil bit

    localparam logic [PW-1:0] Nil = 14'h2000;

    localparam logic [1:0] CmdLoad    = 2'd0;
    localparam logic [1:0] CmdCompute = 2'd1;
    localparam logic [1:0] CmdQuery   = 2'd2;
    localparam logic [1:0] CmdClear   = 2'd3;

    localparam logic [1:0] StOk       = 2'd0;
    localparam logic [1:0] StFull     = 2'd1;
    localparam logic [1:0] StRange    = 2'd2;
    localparam logic [1:0] StNotDone  = 2'd3;

    typedef struct packed {
        logic [1:0]    cmd;
        logic [VW-1:0] node_a;
        logic [VW-1:0] node_b;
    } t_in;

    typedef struct packed {
        logic [1:0]    status;
        logic [VW-1:0] component_id;
        logic [NW-1:0] component_count;
    } t_res;

    typedef struct packed {
        logic [PW-1:0] head;
        logic [PW-1:0] tail;
    } t_ht;

    typedef struct packed {
        logic [VW-1:0] v;
        logic [VW-1:0] par;
        logic [PW-1:0] it;
        logic          hp;
        logic          skip;
        logic [VW-1:0] low;
        logic [VW-1:0] disc;
    } t_frame;

    typedef struct packed {
        logic          vis;
        logic [VW-1:0] disc;
    } t_vinfo;

endpackage

FILE: rtl/core/tecc_ram.sv
// ----------------------------------------------------------------------------
// tecc_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tecc_ram #(
    parameter int W  = 8,
    parameter int D  = 1024,
    parameter int AW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end
endmodule

FILE: rtl/core/two_edge_connected_components.sv
// ----------------------------------------------------------------------------
// two_edge_connected_components
// bridge-based edge-biconnected components over a memory-resident multigraph
// ----------------------------------------------------------------------------
// a load or query with an error is answered from idle; clear sweeps the heads again
// compute is bound by the single read port of the edge and vertex memories
// walked by the depth-first sequencer
// one transaction at a time; the result strobe lasts one cycle and cannot be stalled
// reset (i_rst_n low, synchronous) starts a sweep of all adjacency heads during
// which busy is high; node_count resets to 1
module two_edge_connected_components (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  tecc_pkg::t_in        i_in,
    input  logic                 i_cfg_we,
    input  logic [10:0]          i_cfg_data,
    output logic                 o_valid,
    output tecc_pkg::t_res       o_res
);
    typedef enum logic [15:0] {
        S_INIT = 16'h0001, S_IDLE = 16'h0002, S_LRD  = 16'h0004, S_LW1  = 16'h0008,
        S_LW2  = 16'h0010, S_CSW  = 16'h0020, S_ROOT = 16'h0040, S_RCHK = 16'h0080,
        S_ITER = 16'h0100, S_EDGE = 16'h0200, S_VIS  = 16'h0400, S_FIN  = 16'h0800,
        S_POPV = 16'h1000, S_RET  = 16'h2000, S_REST = 16'h4000, S_QRY  = 16'h8000
    } t_state;

    t_state r_state;
    logic [10:0] r_ncfg, r_cnt, r_root, r_d, r_vtop, r_time, r_cc;
    logic [12:0] r_et;
    logic        r_computed, r_resp, r_side;
    logic [9:0]  r_a, r_b, r_u;
    logic [13:0] r_tail;
    tecc_pkg::t_frame r_f;

    logic [10:0] n_eff;
    logic [9:0]  from_v, to_v;
    logic [12:0] slot;
    logic [1:0]  st_cmd;
    logic        n_valid;

    // memory ports
    logic et_we;  logic [12:0] et_wa, et_ra; logic [9:0]  et_wd, et_rd;
    logic en_we;  logic [12:0] en_wa, en_ra; logic [13:0] en_wd, en_rd;
    logic ht_we;  logic [9:0]  ht_wa, ht_ra; tecc_pkg::t_ht ht_wd, ht_rd;
    logic vi_we;  logic [9:0]  vi_wa, vi_ra; tecc_pkg::t_vinfo vi_wd, vi_rd;
    logic co_we;  logic [9:0]  co_wa, co_ra; logic [9:0]  co_wd, co_rd;
    logic vs_we;  logic [9:0]  vs_wa, vs_ra; logic [9:0]  vs_wd, vs_rd;
    logic cs_we;  logic [9:0]  cs_wa, cs_ra; tecc_pkg::t_frame cs_wd, cs_rd;

    tecc_ram #(.W(10), .D(tecc_pkg::Slots)) u_et (.i_clk, .i_we(et_we), .i_waddr(et_wa),
        .i_wdata(et_wd), .i_raddr(et_ra), .o_rdata(et_rd));
    tecc_ram #(.W(14), .D(tecc_pkg::Slots)) u_en (.i_clk, .i_we(en_we), .i_waddr(en_wa),
        .i_wdata(en_wd), .i_raddr(en_ra), .o_rdata(en_rd));
    tecc_ram #(.W(28), .D(tecc_pkg::MaxNodes)) u_ht (.i_clk, .i_we(ht_we), .i_waddr(ht_wa),
        .i_wdata(ht_wd), .i_raddr(ht_ra), .o_rdata(ht_rd));
    tecc_ram #(.W(11), .D(tecc_pkg::MaxNodes)) u_vi (.i_clk, .i_we(vi_we), .i_waddr(vi_wa),
        .i_wdata(vi_wd), .i_raddr(vi_ra), .o_rdata(vi_rd));
    tecc_ram #(.W(10), .D(tecc_pkg::MaxNodes)) u_co (.i_clk, .i_we(co_we), .i_waddr(co_wa),
        .i_wdata(co_wd), .i_raddr(co_ra), .o_rdata(co_rd));
    tecc_ram #(.W(10), .D(tecc_pkg::MaxNodes)) u_vs (.i_clk, .i_we(vs_we), .i_waddr(vs_wa),
        .i_wdata(vs_wd), .i_raddr(vs_ra), .o_rdata(vs_rd));
    tecc_ram #(.W(56), .D(tecc_pkg::MaxNodes)) u_cs (.i_clk, .i_we(cs_we), .i_waddr(cs_wa),
        .i_wdata(cs_wd), .i_raddr(cs_ra), .o_rdata(cs_rd));

    assign n_eff  = (r_ncfg == 11'd0) ? 11'd1 :
                    (r_ncfg > 11'd1024) ? 11'd1024 : r_ncfg;
    assign from_v = r_side ? r_b : r_a;
    assign to_v   = r_side ? r_a : r_b;
    assign slot   = {r_et[11:0], r_side};
    assign busy   = (r_state != S_IDLE);

    // immediate status of a command in idle
    always_comb begin
        st_cmd = tecc_pkg::StOk;
        unique case (i_in.cmd)
            tecc_pkg::CmdLoad: begin
                if ({1'b0, i_in.node_a} >= n_eff || {1'b0, i_in.node_b} >= n_eff) begin
                    st_cmd = tecc_pkg::StRange;
                end else if (r_et[12]) begin
                    st_cmd = tecc_pkg::StFull;
                end
            end
            tecc_pkg::CmdQuery: begin
                if (!r_computed) begin
                    st_cmd = tecc_pkg::StNotDone;
                end else if ({1'b0, i_in.node_a} >= n_eff) begin
                    st_cmd = tecc_pkg::StRange;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_valid = 1'b0;
        unique case (r_state) inside
            S_INIT: n_valid = r_resp && (r_cnt == 11'd1023);
            S_IDLE: n_valid = start && (st_cmd != tecc_pkg::StOk);
            S_QRY:  n_valid = 1'b1;
            S_LW1:  n_valid = ht_rd.tail[13] && r_side;
            S_LW2:  n_valid = r_side;
            S_ROOT: n_valid = (r_root == n_eff);
            default: n_valid = 1'b0;
        endcase
    end

    always_comb begin
        et_we = 1'b0; et_wa = slot; et_wd = to_v; et_ra = r_f.it[12:0];
        en_we = 1'b0; en_wa = slot; en_wd = tecc_pkg::Nil; en_ra = r_f.it[12:0];
        ht_we = 1'b0; ht_wa = from_v; ht_ra = from_v;
        ht_wd = '{head: tecc_pkg::Nil, tail: tecc_pkg::Nil};
        vi_we = 1'b0; vi_wa = r_u; vi_wd = '{vis: 1'b1, disc: r_time[9:0]}; vi_ra = r_u;
        co_we = 1'b0; co_wa = vs_rd; co_wd = r_cc[9:0]; co_ra = i_in.node_a;
        vs_we = 1'b0; vs_wa = r_vtop[9:0]; vs_wd = r_u; vs_ra = r_vtop[9:0] - 10'd1;
        cs_we = 1'b0; cs_wa = r_d[9:0] - 10'd1; cs_wd = r_f; cs_ra = r_d[9:0] - 10'd2;
        unique case (r_state) inside
            S_INIT: begin
                ht_we = 1'b1; ht_wa = r_cnt[9:0];
            end
            S_LW1: begin
                et_we = 1'b1; en_we = 1'b1; ht_we = 1'b1;
                ht_wd.head = ht_rd.tail[13] ? {1'b0, slot} : ht_rd.head;
                ht_wd.tail = {1'b0, slot};
            end
            S_LW2: begin
                en_we = 1'b1; en_wa = r_tail[12:0]; en_wd = {1'b0, slot};
            end
            S_CSW: begin
                vi_we = 1'b1; vi_wa = r_cnt[9:0]; vi_wd = '{vis: 1'b0, disc: 10'd0};
            end
            S_ROOT: begin
                vi_ra = r_root[9:0]; ht_ra = r_root[9:0];
            end
            S_EDGE: begin
                vi_ra = et_rd; ht_ra = et_rd;
            end
            S_RCHK, S_VIS: begin
                if (!vi_rd.vis) begin
                    vi_we = 1'b1; vs_we = 1'b1;
                    cs_we = (r_state == S_VIS);
                end
            end
            S_POPV: begin
                co_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_cnt      <= '0;
            r_ncfg     <= 11'd1;
            r_et       <= '0;
            r_computed <= 1'b0;
            r_cc       <= '0;
            r_resp     <= 1'b0;
            r_side     <= 1'b0;
            r_d        <= '0;
            r_vtop     <= '0;
            r_time     <= '0;
            r_root     <= '0;
            o_valid    <= 1'b0;
        end else begin
            o_valid <= n_valid;
            if (i_cfg_we) begin
                r_ncfg     <= i_cfg_data;
                r_computed <= 1'b0;
            end
            unique case (r_state) inside
                S_INIT: begin
                    r_cnt <= r_cnt + 11'd1;
                    if (r_cnt == 11'd1023) begin
                        r_state <= S_IDLE;
                        if (r_resp) begin
                            o_res   <= '{status: tecc_pkg::StOk, component_id: '0,
                                         component_count: '0};
                        end
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_a    <= i_in.node_a;
                        r_b    <= i_in.node_b;
                        r_side <= 1'b0;
                        r_cnt  <= '0;
                        o_res  <= '{status: st_cmd, component_id: '0,
                                    component_count: r_computed ? r_cc : 11'd0};
                        unique case (i_in.cmd)
                            tecc_pkg::CmdLoad: begin
                                if (st_cmd == tecc_pkg::StOk) begin
                                    r_state <= S_LRD;
                                end
                            end
                            tecc_pkg::CmdCompute: begin
                                r_state <= S_CSW;
                            end
                            tecc_pkg::CmdQuery: begin
                                if (st_cmd == tecc_pkg::StOk) begin
                                    r_state <= S_QRY;
                                end
                            end
                            default: begin
                                r_state    <= S_INIT;
                                r_resp     <= 1'b1;
                                r_et       <= '0;
                                r_computed <= 1'b0;
                                r_cc       <= '0;
                            end
                        endcase
                    end
                end
                S_QRY: begin
                    o_res.component_id <= co_rd;
                    r_state            <= S_IDLE;
                end
                S_LRD: begin
                    r_state <= S_LW1;
                end
                S_LW1: begin
                    r_tail <= ht_rd.tail;
                    if (!ht_rd.tail[13]) begin
                        r_state <= S_LW2;
                    end else if (!r_side) begin
                        r_side  <= 1'b1;
                        r_state <= S_LRD;
                    end else begin
                        r_et       <= r_et + 13'd1;
                        r_computed <= 1'b0;
                        o_res      <= '{status: tecc_pkg::StOk, component_id: '0,
                                        component_count: '0};
                        r_state    <= S_IDLE;
                    end
                end
                S_LW2: begin
                    if (!r_side) begin
                        r_side  <= 1'b1;
                        r_state <= S_LRD;
                    end else begin
                        r_et       <= r_et + 13'd1;
                        r_computed <= 1'b0;
                        o_res      <= '{status: tecc_pkg::StOk, component_id: '0,
                                        component_count: '0};
                        r_state    <= S_IDLE;
                    end
                end
                S_CSW: begin
                    r_cnt <= r_cnt + 11'd1;
                    if (r_cnt == 11'd1023) begin
                        r_root  <= '0;
                        r_time  <= '0;
                        r_cc    <= '0;
                        r_vtop  <= '0;
                        r_d     <= '0;
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    r_u <= r_root[9:0];
                    if (r_root == n_eff) begin
                        r_computed <= 1'b1;
                        o_res      <= '{status: tecc_pkg::StOk, component_id: '0,
                                        component_count: r_cc};
                        r_state    <= S_IDLE;
                    end else begin
                        r_state <= S_RCHK;
                    end
                end
                S_RCHK, S_VIS: begin
                    if (vi_rd.vis) begin
                        if (r_state == S_RCHK) begin
                            r_root  <= r_root + 11'd1;
                            r_state <= S_ROOT;
                        end else begin
                            if (vi_rd.disc < r_f.low) begin
                                r_f.low <= vi_rd.disc;
                            end
                            r_state <= S_ITER;
                        end
                    end else begin
                        r_f.v    <= r_u;
                        r_f.par  <= r_f.v;
                        r_f.it   <= ht_rd.head;
                        r_f.hp   <= (r_state == S_VIS);
                        r_f.skip <= 1'b0;
                        r_f.low  <= r_time[9:0];
                        r_f.disc <= r_time[9:0];
                        r_time   <= r_time + 11'd1;
                        r_vtop   <= r_vtop + 11'd1;
                        r_d      <= r_d + 11'd1;
                        r_state  <= S_ITER;
                    end
                end
                S_ITER: begin
                    r_state <= r_f.it[13] ? S_FIN : S_EDGE;
                end
                S_EDGE: begin
                    r_f.it <= en_rd;
                    r_u    <= et_rd;
                    if ({1'b0, et_rd} >= n_eff) begin
                        r_state <= S_ITER;
                    end else if (r_f.hp && et_rd == r_f.par && !r_f.skip) begin
                        r_f.skip <= 1'b1;
                        r_state  <= S_ITER;
                    end else begin
                        r_state <= S_VIS;
                    end
                end
                S_FIN: begin
                    r_state <= (r_f.low == r_f.disc) ? S_POPV : S_RET;
                end
                S_POPV: begin
                    r_vtop <= r_vtop - 11'd1;
                    if (vs_rd == r_f.v) begin
                        r_cc    <= r_cc + 11'd1;
                        r_state <= S_RET;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_RET: begin
                    r_d <= r_d - 11'd1;
                    if (r_d == 11'd1) begin
                        r_root  <= r_root + 11'd1;
                        r_state <= S_ROOT;
                    end else begin
                        r_state <= S_REST;
                    end
                end
                S_REST: begin
                    r_f     <= '{v: cs_rd.v, par: cs_rd.par, it: cs_rd.it, hp: cs_rd.hp,
                                 skip: cs_rd.skip,
                                 low: (cs_rd.low < r_f.low) ? cs_rd.low : r_f.low,
                                 disc: cs_rd.disc};
                    r_state <= S_ITER;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

FILE: dv/two_edge_connected_components_test.sv
// ----------------------------------------------------------------------------
// two_edge_connected_components_test
// Drives load, compute, query and clear transactions into the edge-biconnected
// component engine, and checks every result against a predictor that tracks
// the adjacency store and repeats the depth-first bridge search on compute.
// The run covers several node_count settings (the extremes among them),
// stale edges, and random multigraphs with random gaps.
// ----------------------------------------------------------------------------
module two_edge_connected_components_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Limit = 3000000;
    localparam int NoLink = -1;

    logic                 clk;
    logic                 rst_n;
    logic                 start = 1'b0;
    logic                 busy;
    tecc_pkg::t_in        in_item = '0;
    logic                 cfg_we;
    logic [10:0]          cfg_data;
    logic                 o_valid;
    tecc_pkg::t_res       res;

    two_edge_connected_components DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (in_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .o_valid    (o_valid),
        .o_res      (res)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // graph model
    int m_target [tecc_pkg::Slots];
    int m_next   [tecc_pkg::Slots];
    int m_head   [tecc_pkg::MaxNodes];
    int m_tail   [tecc_pkg::MaxNodes];
    int m_edges;
    int m_nodes;
    bit m_done;
    int m_ncomp;
    bit m_vis    [tecc_pkg::MaxNodes];
    int m_disc   [tecc_pkg::MaxNodes];
    int m_low    [tecc_pkg::MaxNodes];
    int m_comp   [tecc_pkg::MaxNodes];
    int m_vstack [tecc_pkg::MaxNodes];
    int m_top;
    int m_time;
    int f_v      [tecc_pkg::MaxNodes];
    int f_par    [tecc_pkg::MaxNodes];
    int f_it     [tecc_pkg::MaxNodes];
    bit f_hp     [tecc_pkg::MaxNodes];
    bit f_skip   [tecc_pkg::MaxNodes];
    int m_sp;

    tecc_pkg::t_in  pend_cmds [$];
    tecc_pkg::t_res pending_results [$];
    int   errors = 0;
    int   n_items = 0;
    int   cycles = 0;
    int   gap_left = 0;
    int   max_gap;
    bit   took = 1'b0;

    function automatic int eff_nodes();
        if (m_nodes < 1) return 1;
        if (m_nodes > tecc_pkg::MaxNodes) return tecc_pkg::MaxNodes;
        return m_nodes;
    endfunction

    function automatic void clear_store();
        for (int i = 0; i < tecc_pkg::MaxNodes; i++) begin
            m_head[i] = NoLink;
            m_tail[i] = NoLink;
        end
        m_edges = 0;
        m_done = 0;
        m_ncomp = 0;
    endfunction

    function automatic void link_slot(int slot, int from, int to);
        m_target[slot] = to;
        m_next[slot] = NoLink;
        if (m_tail[from] == NoLink) m_head[from] = slot;
        else m_next[m_tail[from]] = slot;
        m_tail[from] = slot;
    endfunction

    function automatic void enter_vertex(int v, int par, bit hp);
        m_vis[v] = 1;
        m_disc[v] = m_time;
        m_low[v] = m_time;
        m_time++;
        m_vstack[m_top++] = v;
        f_v[m_sp] = v;
        f_par[m_sp] = par;
        f_it[m_sp] = m_head[v];
        f_hp[m_sp] = hp;
        f_skip[m_sp] = 0;
        m_sp++;
    endfunction

    function automatic void label_components();
        int n, v, e, u, x;
        n = eff_nodes();
        for (int i = 0; i < tecc_pkg::MaxNodes; i++) m_vis[i] = 0;
        m_time = 0;
        m_ncomp = 0;
        m_top = 0;
        for (int root = 0; root < n; root++) begin
            if (m_vis[root]) continue;
            m_sp = 0;
            enter_vertex(root, 0, 0);
            while (m_sp > 0) begin
                v = f_v[m_sp-1];
                if (f_it[m_sp-1] != NoLink) begin
                    e = f_it[m_sp-1];
                    u = m_target[e];
                    f_it[m_sp-1] = m_next[e];
                    if (u >= n) continue;
                    if (f_hp[m_sp-1] && u == f_par[m_sp-1] && !f_skip[m_sp-1]) begin
                        f_skip[m_sp-1] = 1;
                        continue;
                    end
                    if (m_vis[u]) begin
                        if (m_disc[u] < m_low[v]) m_low[v] = m_disc[u];
                    end else begin
                        enter_vertex(u, v, 1);
                    end
                    continue;
                end
                if (m_low[v] == m_disc[v]) begin
                    while (m_top > 0) begin
                        m_top--;
                        x = m_vstack[m_top];
                        m_comp[x] = m_ncomp;
                        if (x == v) break;
                    end
                    m_ncomp++;
                end
                m_sp--;
                if (m_sp > 0 && m_low[v] < m_low[f_v[m_sp-1]]) m_low[f_v[m_sp-1]] = m_low[v];
            end
        end
        m_done = 1;
    endfunction

    function automatic tecc_pkg::t_res predict_cmd(tecc_pkg::t_in x);
        tecc_pkg::t_res r;
        int n, a, b;
        r = '0;
        n = eff_nodes();
        a = x.node_a;
        b = x.node_b;
        case (x.cmd)
            tecc_pkg::CmdLoad: begin
                if (a >= n || b >= n) begin
                    r.status = tecc_pkg::StRange;
                end else if (m_edges >= tecc_pkg::MaxEdges) begin
                    r.status = tecc_pkg::StFull;
                end else begin
                    link_slot(m_edges * 2, a, b);
                    link_slot(m_edges * 2 + 1, b, a);
                    m_edges++;
                    m_done = 0;
                end
            end
            tecc_pkg::CmdCompute: label_components();
            tecc_pkg::CmdQuery: begin
                if (!m_done) r.status = tecc_pkg::StNotDone;
                else if (a >= n) r.status = tecc_pkg::StRange;
                else r.component_id = m_comp[a][tecc_pkg::VW-1:0];
            end
            default: clear_store();
        endcase
        r.component_count = m_done ? m_ncomp[tecc_pkg::NW-1:0] : '0;
        return r;
    endfunction

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    // driver
    always @(negedge clk) begin : drv
        logic nxt_start;
        nxt_start = start;
        if (start && took) nxt_start = 1'b0;
        if (!nxt_start && rst_n) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pend_cmds.size() > 0) begin
                in_item <= pend_cmds.pop_front();
                nxt_start = 1'b1;
                gap_left = $urandom_range(0, max_gap);
            end
        end
        start <= nxt_start;
    end

    // monitor
    always @(posedge clk) begin : mon
        tecc_pkg::t_res e;
        took = 1'b0;
        cycles++;
        if (rst_n) begin
            if (o_valid) begin
                if (pending_results.size() == 0) begin
                    report("result transaction with nothing outstanding");
                end else begin
                    e = pending_results.pop_front();
                    if (res.status !== e.status)
                        report($sformatf("status %0d, want %0d", res.status, e.status));
                    if (res.component_id !== e.component_id)
                        report($sformatf("component_id %0d, want %0d",
                                         res.component_id, e.component_id));
                    if (res.component_count !== e.component_count)
                        report($sformatf("component_count %0d, want %0d",
                                         res.component_count, e.component_count));
                end
            end
            if (start && !busy) begin
                took = 1'b1;
                e = predict_cmd(in_item);
                pending_results = {pending_results, e};
                n_items++;
            end
        end
        if (cycles > Limit) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void add(logic [1:0] c, int a, int b);
        tecc_pkg::t_in x;
        x.cmd = c;
        x.node_a = a[tecc_pkg::VW-1:0];
        x.node_b = b[tecc_pkg::VW-1:0];
        pend_cmds = {pend_cmds, x};
    endfunction

    task automatic wait_idle();
        do @(posedge clk);
        while (pend_cmds.size() != 0 || start || pending_results.size() != 0 || busy);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(int v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v[10:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        m_nodes = v & 11'h7ff;
        m_done = 0;
    endtask

    task automatic rand_graph(int count, int n);
        int r, hi;
        hi = (n > tecc_pkg::MaxNodes) ? tecc_pkg::MaxNodes - 1 : n - 1;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                add(tecc_pkg::CmdLoad, $urandom_range(0, hi), $urandom_range(0, hi));
            else if (r < 62)
                add(tecc_pkg::CmdLoad, $urandom_range(0, 1023), $urandom_range(0, 1023));
            else if (r < 75)
                add(tecc_pkg::CmdQuery, $urandom_range(0, hi), 0);
            else if (r < 88)
                add(tecc_pkg::CmdCompute, 0, 0);
            else if (r < 92)
                add(tecc_pkg::CmdClear, 0, 0);
            else
                add(tecc_pkg::CmdQuery, $urandom_range(0, 1023), $urandom_range(0, 1023));
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        max_gap = 14;
        m_nodes = 1;
        clear_store();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // single vertex at reset value
        add(tecc_pkg::CmdQuery, 0, 0);
        add(tecc_pkg::CmdLoad, 0, 0);
        add(tecc_pkg::CmdLoad, 0, 1);
        add(tecc_pkg::CmdCompute, 0, 0);
        add(tecc_pkg::CmdQuery, 0, 0);
        add(tecc_pkg::CmdQuery, 1, 0);
        add(tecc_pkg::CmdQuery, 1023, 0);
        wait_idle();

        // clamp high: parallel edges, a bridge, a triangle, self loop
        write_cfg(2047);
        add(tecc_pkg::CmdLoad, 1023, 1023);
        add(tecc_pkg::CmdLoad, 0, 1023);
        add(tecc_pkg::CmdLoad, 5, 6);
        add(tecc_pkg::CmdLoad, 5, 6);
        add(tecc_pkg::CmdLoad, 6, 7);
        add(tecc_pkg::CmdLoad, 1, 2);
        add(tecc_pkg::CmdLoad, 2, 3);
        add(tecc_pkg::CmdLoad, 3, 1);
        add(tecc_pkg::CmdCompute, 0, 0);
        add(tecc_pkg::CmdQuery, 5, 0);
        add(tecc_pkg::CmdQuery, 7, 0);
        add(tecc_pkg::CmdQuery, 1023, 0);
        add(tecc_pkg::CmdClear, 0, 0);
        add(tecc_pkg::CmdQuery, 0, 0);
        add(tecc_pkg::CmdCompute, 0, 0);
        add(tecc_pkg::CmdQuery, 1023, 0);
        wait_idle();

        // clamp low
        write_cfg(0);
        add(tecc_pkg::CmdLoad, 0, 0);
        add(tecc_pkg::CmdCompute, 0, 0);
        add(tecc_pkg::CmdQuery, 0, 0);
        wait_idle();

        // random small graphs, with a back-to-back stretch
        write_cfg(24);
        add(tecc_pkg::CmdClear, 0, 0);
        rand_graph(20, 24);
        wait_idle();
        max_gap = 0;
        write_cfg(40);
        rand_graph(20, 40);
        for (int i = 0; i < 10; i++)
            add(tecc_pkg::CmdLoad, $urandom_range(0, 39), $urandom_range(0, 39));
        wait_idle();
        max_gap = 14;
        // stale edges after shrinking the vertex count
        write_cfg(20);
        add(tecc_pkg::CmdCompute, 0, 0);
        for (int i = 0; i < 6; i++) add(tecc_pkg::CmdQuery, $urandom_range(0, 25), 0);
        wait_idle();
        write_cfg(1024);
        rand_graph(20, 1024);
        wait_idle();

        write_cfg(600);
        add(tecc_pkg::CmdLoad, 700, 3);
        add(tecc_pkg::CmdLoad, 3, 4);
        add(tecc_pkg::CmdCompute, 0, 0);
        add(tecc_pkg::CmdQuery, 599, 0);
        add(tecc_pkg::CmdQuery, 600, 0);
        wait_idle();

        repeat (20) @(posedge clk);
        $display("%0d transactions: node_count extremes, stale edges, out-of-range ids,",
                 n_items);
        $display("parallel edges, self loops and random multigraphs with random gaps");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
